// ===== design/skl_pkg.sv =====
// ----------------------------------------------------------------------------
// skl_pkg: shared types and codes for the static key list engine
// Request codes, status codes, key width and the sequencer state type.
// ----------------------------------------------------------------------------
package skl_pkg;

    localparam int KEY_W = 32;

    typedef logic [KEY_W-1:0] t_key;

    // request codes
    localparam logic [2:0] REQ_APPEND     = 3'd0;
    localparam logic [2:0] REQ_APPEND_UNQ = 3'd1;
    localparam logic [2:0] REQ_INSERT_AT  = 3'd2;
    localparam logic [2:0] REQ_SORTED_INS = 3'd3;
    localparam logic [2:0] REQ_REMOVE     = 3'd4;
    localparam logic [2:0] REQ_FIND       = 3'd5;
    localparam logic [2:0] REQ_READ_AT    = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_DUP      = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

endpackage

// ===== design/skl_cell.sv =====
// ----------------------------------------------------------------------------
// skl_cell: one storage cell of the key ring
// Holds one key and loads the key on its input on every shift.
// ----------------------------------------------------------------------------
module skl_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  skl_pkg::t_key i_key,
    output skl_pkg::t_key o_key
);

    skl_pkg::t_key r_key;

    // advance the ring by one place
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key <= i_key;
        end
    end

    assign o_key = r_key;

endmodule

// ===== design/static_key_list_engine.sv =====
// One request in flight: a new request is taken only after the result of the
// last one has been loaded into the output register. Each request rotates the
// cell ring by one full turn, one place a cycle, and then loads the result;
// that load waits while the previous result is still held unaccepted.
// Reset (synchronous, active low) empties the list; cell contents stay
// undefined until written and are never shown before that.
// ----------------------------------------------------------------------------
// static_key_list_engine: fixed-capacity list of signed 32-bit keys
// Keys sit in a ring of cells that rotates once per request; the sequencer
// watches the head cell and rewrites the tail to insert, remove or read.
// ----------------------------------------------------------------------------
module static_key_list_engine #(
    parameter int CAPACITY = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic signed [31:0] i_key_in,
    input  logic [6:0]  i_position_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [6:0]  o_position_out,
    output logic signed [31:0] o_key_out,
    output logic [7:0]  o_entry_count,
    output logic        o_is_full,
    output logic        o_is_empty
);

    localparam int CW = $clog2(CAPACITY + 1);

    // ring of cells
    skl_pkg::t_key w_cell [CAPACITY];
    skl_pkg::t_key w_tail;
    logic          w_shift;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == CAPACITY - 1) begin : g_last
            skl_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_key  (w_tail),
                .o_key  (w_cell[g])
            );
        end else begin : g_mid
            skl_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_key  (w_cell[g+1]),
                .o_key  (w_cell[g])
            );
        end
    end

    // sequencer registers
    skl_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_k, n_k;
    logic [2:0]      r_req;
    skl_pkg::t_key   r_key;
    logic [CW-1:0]   r_pos;
    logic [2:0]      r_err, n_err;
    logic            r_ins, n_ins;
    logic            r_del, n_del;
    logic            r_hit, n_hit;
    logic [CW-1:0]   r_hitpos, n_hitpos;
    skl_pkg::t_key   r_carry, n_carry;
    skl_pkg::t_key   r_rdkey, n_rdkey;

    // output register
    logic            r_out_valid;
    logic [2:0]      r_status, n_status;
    logic [6:0]      r_pos_out, n_pos_out;
    skl_pkg::t_key   r_key_out, n_key_out;
    logic [7:0]      r_cnt_out;
    logic            r_full_out, r_empty_out;

    logic w_accept, w_load_out, w_last;
    logic [31:0] w_pos32, w_cnt32;
    logic [CW-1:0] w_pos_in;

    assign w_accept = i_in_valid & o_in_ready;
    assign w_last   = (r_k == CW'(CAPACITY - 1));
    assign w_pos32  = 32'(i_position_in);
    assign w_pos_in = w_pos32[CW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            skl_pkg::S_IDLE: if (w_accept) n_state = skl_pkg::S_SCAN;
            skl_pkg::S_SCAN: if (w_last) n_state = skl_pkg::S_FIN;
            skl_pkg::S_FIN:  if (!r_out_valid || i_out_ready) n_state = skl_pkg::S_IDLE;
            default:         n_state = skl_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_shift    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            skl_pkg::S_IDLE: o_in_ready = 1'b1;
            skl_pkg::S_SCAN: w_shift    = 1'b1;
            skl_pkg::S_FIN:  w_load_out = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // per-step ring rewrite and request bookkeeping
    logic w_active, w_eq, w_trig;
    always_comb begin
        w_active = ({1'b0, r_k} < {1'b0, r_count});
        w_eq     = w_active && (w_cell[0] == r_key) && !r_hit;
        w_trig   = 1'b0;
        case (r_req)
            skl_pkg::REQ_APPEND:     w_trig = (r_k == r_count);
            skl_pkg::REQ_APPEND_UNQ: w_trig = (r_k == r_count) && !r_hit;
            skl_pkg::REQ_INSERT_AT:  w_trig = (r_k == r_pos);
            skl_pkg::REQ_SORTED_INS: w_trig = (r_k == r_count) ||
                (w_active && !($signed(w_cell[0]) < $signed(r_key)));
            default:                 w_trig = 1'b0;
        endcase
        if (r_err != skl_pkg::ST_OK) w_trig = 1'b0;

        w_tail   = w_cell[0];
        n_carry  = r_carry;
        n_ins    = r_ins;
        n_del    = r_del;
        n_hit    = r_hit;
        n_hitpos = r_hitpos;
        n_rdkey  = r_rdkey;
        if (r_del) begin
            w_tail = w_cell[1];
        end else if (r_ins) begin
            w_tail  = r_carry;
            n_carry = w_cell[0];
        end else if (w_trig) begin
            w_tail   = r_key;
            n_carry  = w_cell[0];
            n_ins    = 1'b1;
            n_hitpos = r_k;
        end else if (w_eq && (r_req == skl_pkg::REQ_REMOVE)) begin
            w_tail   = w_cell[1];
            n_del    = 1'b1;
            n_hit    = 1'b1;
            n_hitpos = r_k;
        end else if (w_eq && (r_req == skl_pkg::REQ_FIND ||
                              r_req == skl_pkg::REQ_APPEND_UNQ)) begin
            n_hit    = 1'b1;
            n_hitpos = r_k;
        end
        if (r_req == skl_pkg::REQ_READ_AT && r_k == r_pos && r_err == skl_pkg::ST_OK) begin
            n_rdkey = w_cell[0];
        end
    end

    // request intake checks
    always_comb begin
        n_err = skl_pkg::ST_OK;
        case (i_req_type)
            skl_pkg::REQ_APPEND, skl_pkg::REQ_APPEND_UNQ, skl_pkg::REQ_SORTED_INS:
                if (r_count == CW'(CAPACITY)) n_err = skl_pkg::ST_FULL;
            skl_pkg::REQ_INSERT_AT:
                if (r_count == CW'(CAPACITY)) n_err = skl_pkg::ST_FULL;
                else if (w_pos32 > 32'(r_count)) n_err = skl_pkg::ST_BADPOS;
            skl_pkg::REQ_READ_AT:
                if (w_pos32 >= 32'(r_count)) n_err = skl_pkg::ST_BADPOS;
            default: n_err = skl_pkg::ST_OK;
        endcase
    end

    // final result
    always_comb begin
        n_count   = r_count;
        n_status  = r_err;
        n_key_out = r_key;
        w_cnt32   = 32'(r_hitpos);
        n_pos_out = w_cnt32[6:0];
        if (r_ins) n_count = r_count + CW'(1);
        if (r_del) n_count = r_count - CW'(1);
        if (r_err == skl_pkg::ST_OK) begin
            if (r_req == skl_pkg::REQ_APPEND_UNQ && r_hit) begin
                n_status = skl_pkg::ST_DUP;
            end else if ((r_req == skl_pkg::REQ_REMOVE || r_req == skl_pkg::REQ_FIND)
                         && !r_hit) begin
                n_status = skl_pkg::ST_NOTFOUND;
            end
        end
        if (r_req == skl_pkg::REQ_READ_AT && r_err == skl_pkg::ST_OK) begin
            n_key_out = r_rdkey;
        end
        if (n_status != skl_pkg::ST_OK) n_pos_out = 7'd0;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skl_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and scan registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req    <= i_req_type;
            r_key    <= i_key_in;
            r_pos    <= w_pos_in;
            r_err    <= n_err;
            r_k      <= '0;
            r_ins    <= 1'b0;
            r_del    <= 1'b0;
            r_hit    <= 1'b0;
            r_hitpos <= (i_req_type == skl_pkg::REQ_READ_AT) ? w_pos_in : '0;
        end else if (w_shift) begin
            r_k      <= n_k;
            r_ins    <= n_ins;
            r_del    <= n_del;
            r_hit    <= n_hit;
            r_hitpos <= n_hitpos;
            r_carry  <= n_carry;
            r_rdkey  <= n_rdkey;
        end
    end

    assign n_k = r_k + CW'(1);

    // hold the result until transfer
    logic [31:0] w_cnt_next32;
    assign w_cnt_next32 = 32'(n_count);
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_status    <= n_status;
            r_pos_out   <= n_pos_out;
            r_key_out   <= n_key_out;
            r_cnt_out   <= w_cnt_next32[7:0];
            r_full_out  <= (n_count == CW'(CAPACITY));
            r_empty_out <= (n_count == '0);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_position_out = r_pos_out;
    assign o_key_out      = r_key_out;
    assign o_entry_count  = r_cnt_out;
    assign o_is_full      = r_full_out;
    assign o_is_empty     = r_empty_out;

endmodule

// ===== test/static_key_list_engine_tb.sv =====
// ----------------------------------------------------------------------------
// static_key_list_engine_tb: self-checking bench for the static key list engine
// Drives list requests over a valid/ready channel, mirrors the list in a
// behavioral copy, and compares each returned result field by field.
// ----------------------------------------------------------------------------
module static_key_list_engine_tb;

    localparam int CAP        = 128;
    localparam int WDOG_LIMIT = 20000;
    localparam int IDLE_PCT   = 29;
    localparam int CALM_FROM  = 700;
    localparam int CALM_TO    = 1000;
    localparam int HOLD_AT    = 140;
    localparam int HOLD_LEN   = 400;
    localparam int N_RANDOM   = 1300;
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]         req;
        logic signed [31:0] key;
        logic [6:0]         pos;
    } t_request;

    typedef struct packed {
        logic [2:0]         status;
        logic [6:0]         pos;
        logic signed [31:0] key;
        logic [7:0]         count;
        logic               full;
        logic               empty;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [2:0] i_req_type = '0;
    logic signed [31:0] i_key_in = '0;
    logic [6:0] i_position_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [2:0] o_status;
    logic [6:0] o_position_out;
    logic signed [31:0] o_key_out;
    logic [7:0] o_entry_count;
    logic o_is_full;
    logic o_is_empty;

    static_key_list_engine #(.CAPACITY(CAP)) dut (.*);

    always #5 i_clk = ~i_clk;

    t_request pending_reqs[$];
    t_answer  expected_answers[$];
    logic signed [31:0] list_keys[CAP];
    int  list_len = 0;
    int  errors = 0;
    int  sent_cnt = 0;
    int  hold_off = 0;
    bit  hold_done = 1'b0;
    int  quiet_cycles = 0;

    // idle percentage, with a calm stretch of no idling in the middle of the run
    function automatic int idle_pct_now(int n);
        return (n >= CALM_FROM && n < CALM_TO) ? 0 : IDLE_PCT;
    endfunction

    // advance the list mirror by one request and produce its answer
    function automatic t_answer apply_request(t_request r);
        t_answer a;
        int p;
        a = '0;
        a.key = r.key;
        a.status = skl_pkg::ST_OK;
        p = 0;
        case (r.req)
            skl_pkg::REQ_APPEND, skl_pkg::REQ_APPEND_UNQ, skl_pkg::REQ_INSERT_AT,
            skl_pkg::REQ_SORTED_INS: begin
                if (list_len >= CAP) begin
                    a.status = skl_pkg::ST_FULL;
                end else begin
                    if (r.req == skl_pkg::REQ_APPEND || r.req == skl_pkg::REQ_APPEND_UNQ) begin
                        p = list_len;
                        for (int i = 0; i < list_len; i++)
                            if (r.req == skl_pkg::REQ_APPEND_UNQ && list_keys[i] == r.key)
                                a.status = skl_pkg::ST_DUP;
                    end else if (r.req == skl_pkg::REQ_INSERT_AT) begin
                        p = r.pos;
                        if (r.pos > list_len) a.status = skl_pkg::ST_BADPOS;
                    end else begin
                        while (p < list_len && list_keys[p] < r.key) p++;
                    end
                    if (a.status == skl_pkg::ST_OK) begin
                        for (int i = list_len; i > p; i--) list_keys[i] = list_keys[i-1];
                        list_keys[p] = r.key;
                        list_len++;
                        a.pos = p[6:0];
                    end
                end
            end
            skl_pkg::REQ_REMOVE, skl_pkg::REQ_FIND: begin
                while (p < list_len && list_keys[p] != r.key) p++;
                if (p >= list_len) begin
                    a.status = skl_pkg::ST_NOTFOUND;
                end else begin
                    a.pos = p[6:0];
                    if (r.req == skl_pkg::REQ_REMOVE) begin
                        for (int i = p; i + 1 < list_len; i++) list_keys[i] = list_keys[i+1];
                        list_len--;
                    end
                end
            end
            skl_pkg::REQ_READ_AT: begin
                if (r.pos >= list_len) begin
                    a.status = skl_pkg::ST_BADPOS;
                end else begin
                    a.pos = r.pos;
                    a.key = list_keys[r.pos];
                end
            end
            default: ;
        endcase
        a.count = list_len[7:0];
        a.full  = (list_len >= CAP);
        a.empty = (list_len == 0);
        return a;
    endfunction

    // pick a key, often from the stored ones so find/remove/dup hit
    function automatic logic signed [31:0] pick_key(int shadow_len,
                                                    ref logic signed [31:0] sk[CAP]);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && shadow_len > 0) return sk[$urandom_range(0, shadow_len - 1)];
        if (sel < 7) return $signed($urandom_range(0, 15)) - 8;
        if (sel == 7) return ($urandom_range(0, 1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
        return $signed($urandom());
    endfunction

    // driver: hold the request until transferred
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready) begin
                if (pending_reqs.size() > 0 &&
                    $urandom_range(0, 99) >= idle_pct_now(sent_cnt)) begin
                    i_in_valid    <= 1'b1;
                    i_req_type    <= pending_reqs[0].req;
                    i_key_in      <= pending_reqs[0].key;
                    i_position_in <= pending_reqs[0].pos;
                    sent_cnt      <= sent_cnt + 1;
                    void'(pending_reqs.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off counted here
    always @(posedge i_clk) begin
        if (!hold_done && sent_cnt >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_off    <= HOLD_LEN;
            i_out_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off    <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= idle_pct_now(sent_cnt));
        end
    end

    // monitor: predict on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        t_answer exp_a;
        t_request r;
        bit moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && o_in_ready) begin
                r.req = i_req_type;
                r.key = i_key_in;
                r.pos = i_position_in;
                expected_answers.push_back(apply_request(r));
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result status=%0d key=%0d", $time,
                             o_status, o_key_out);
                    errors++;
                end else begin
                    exp_a = expected_answers.pop_front();
                    if (o_status !== exp_a.status)
                        $display("%0t: status exp %0d got %0d", $time, exp_a.status, o_status);
                    if (o_position_out !== exp_a.pos)
                        $display("%0t: position exp %0d got %0d", $time, exp_a.pos,
                                 o_position_out);
                    if (o_key_out !== exp_a.key)
                        $display("%0t: key exp %0d got %0d", $time, exp_a.key, o_key_out);
                    if (o_entry_count !== exp_a.count)
                        $display("%0t: count exp %0d got %0d", $time, exp_a.count,
                                 o_entry_count);
                    if (o_is_full !== exp_a.full)
                        $display("%0t: full exp %0b got %0b", $time, exp_a.full, o_is_full);
                    if (o_is_empty !== exp_a.empty)
                        $display("%0t: empty exp %0b got %0b", $time, exp_a.empty, o_is_empty);
                    if (o_status !== exp_a.status || o_position_out !== exp_a.pos ||
                        o_key_out !== exp_a.key || o_entry_count !== exp_a.count ||
                        o_is_full !== exp_a.full || o_is_empty !== exp_a.empty)
                        errors++;
                end
            end
            if (moved) quiet_cycles <= 0;
            else       quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic queue_req(logic [2:0] req, logic signed [31:0] key, logic [6:0] pos);
        t_request r;
        r.req = req;
        r.key = key;
        r.pos = pos;
        pending_reqs.push_back(r);
    endtask

    // stimulus plan, tracked with a rough shadow of the list length and keys
    initial begin
        logic signed [31:0] shadow[CAP];
        int  n_len;
        int  mode;
        logic [2:0] req;
        logic signed [31:0] key;
        t_request r;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list errors, extremes, every request, unused code
        queue_req(skl_pkg::REQ_READ_AT, 32'sd0, 7'd0);
        queue_req(skl_pkg::REQ_FIND, 32'sd5, 7'd0);
        queue_req(skl_pkg::REQ_REMOVE, 32'sd5, 7'd0);
        queue_req(skl_pkg::REQ_INSERT_AT, 32'sd9, 7'd1);
        queue_req(skl_pkg::REQ_APPEND, 32'sh7FFFFFFF, 7'd0);
        queue_req(skl_pkg::REQ_APPEND_UNQ, 32'sh7FFFFFFF, 7'd0);
        queue_req(skl_pkg::REQ_APPEND_UNQ, 32'sh80000000, 7'd127);
        queue_req(skl_pkg::REQ_SORTED_INS, -32'sd1, 7'd0);
        queue_req(skl_pkg::REQ_SORTED_INS, 32'sh80000000, 7'd0);
        queue_req(skl_pkg::REQ_INSERT_AT, 32'sd42, 7'd0);
        queue_req(skl_pkg::REQ_INSERT_AT, 32'sd43, 7'd5);
        queue_req(skl_pkg::REQ_READ_AT, 32'sd0, 7'd4);
        queue_req(skl_pkg::REQ_READ_AT, 32'sd0, 7'd5);
        queue_req(skl_pkg::REQ_READ_AT, 32'sd0, 7'd127);
        queue_req(skl_pkg::REQ_FIND, 32'sh80000000, 7'd0);
        queue_req(skl_pkg::REQ_REMOVE, 32'sh80000000, 7'd0);
        queue_req(skl_pkg::REQ_REMOVE, 32'sd43, 7'd0);
        queue_req(REQ_UNUSED, 32'sh5A5A5A5A, 7'h55);

        // fill to capacity, then hit the full checks
        for (int i = 0; i < CAP; i++)
            queue_req(skl_pkg::REQ_APPEND, $signed($urandom()), 7'd0);
        queue_req(skl_pkg::REQ_APPEND, 32'sd1, 7'd0);
        queue_req(skl_pkg::REQ_APPEND_UNQ, 32'sd1, 7'd0);
        queue_req(skl_pkg::REQ_INSERT_AT, 32'sd1, 7'd0);
        queue_req(skl_pkg::REQ_SORTED_INS, 32'sd1, 7'd0);
        queue_req(skl_pkg::REQ_READ_AT, 32'sd0, 7'd127);

        // wait until every request so far has been answered
        while (pending_reqs.size() != 0 || i_in_valid || expected_answers.size() != 0)
            @(posedge i_clk);

        // drain the list so random traffic starts near empty
        n_len = list_len;
        for (int i = 0; i < n_len; i++) shadow[i] = list_keys[i];
        for (int i = 0; i < n_len; i++)
            queue_req(skl_pkg::REQ_REMOVE, shadow[i], 7'($urandom()));
        n_len = 0;

        // random: phases of growth and shrink so both extremes are reached
        for (int i = 0; i < N_RANDOM; i++) begin
            mode = (i / 200) % 2;
            req = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 9) < 4)
                req = mode ? skl_pkg::REQ_REMOVE :
                      (($urandom_range(0, 1)) ? skl_pkg::REQ_APPEND : skl_pkg::REQ_SORTED_INS);
            key = pick_key(n_len, shadow);
            r.req = req;
            r.key = key;
            r.pos = ($urandom_range(0, 3) == 0) ? 7'($urandom()) :
                                                  7'($urandom_range(0, n_len));
            pending_reqs.push_back(r);
            // rough shadow: keep its length and a sample of keys
            if (req <= skl_pkg::REQ_SORTED_INS && n_len < CAP) begin
                shadow[n_len] = key;
                n_len++;
            end else if (req == skl_pkg::REQ_REMOVE && n_len > 0 && $urandom_range(0, 1)) begin
                n_len--;
            end
        end

        while (pending_reqs.size() != 0 || i_in_valid || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (3 * (CAP + 2)) @(posedge i_clk);
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/skl_pkg.sv
design/skl_cell.sv
design/static_key_list_engine.sv
test/static_key_list_engine_tb.sv
